### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands, clocked on the rising edge.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property outside reset.
`define QVR_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define QVR_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/qvr_pkg.sv
// ----------------------------------------------------------------------------
// qvr_pkg
// Shared constants and types of the quaternion vector rotator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package qvr_pkg;

  // Quaternion component width, signed fixed point
  localparam int unsigned QUAT_W = 16;
  // Squared norm: sum of four squares
  localparam int unsigned DEN_W  = 2 * QUAT_W + 1;

  typedef logic [DEN_W-1:0] qvr_den_t;

  typedef struct packed {
    logic neg_x;
    logic neg_y;
    logic neg_z;
    logic zero;
  } qvr_flags_t;

endpackage

`default_nettype wire

### rtl/qvr_if.sv
// ----------------------------------------------------------------------------
// qvr_if
// Item channels of the rotator: quaternion and vector in, rotated vector out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface qvr_in_if #(
  parameter int unsigned VEC_WIDTH = 16
);
  logic                              valid;
  logic                              ready;
  logic signed [qvr_pkg::QUAT_W-1:0] quat_w;
  logic signed [qvr_pkg::QUAT_W-1:0] quat_x;
  logic signed [qvr_pkg::QUAT_W-1:0] quat_y;
  logic signed [qvr_pkg::QUAT_W-1:0] quat_z;
  logic signed [VEC_WIDTH-1:0]       vec_x;
  logic signed [VEC_WIDTH-1:0]       vec_y;
  logic signed [VEC_WIDTH-1:0]       vec_z;

  modport source (
    output valid, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z,
    input  ready
  );
  modport sink (
    input  valid, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z,
    output ready
  );
endinterface

interface qvr_out_if #(
  parameter int unsigned VEC_WIDTH = 16
);
  logic                        valid;
  logic                        ready;
  logic signed [VEC_WIDTH-1:0] rot_x;
  logic signed [VEC_WIDTH-1:0] rot_y;
  logic signed [VEC_WIDTH-1:0] rot_z;
  logic                        clipped;
  logic                        zero_norm;

  modport source (
    output valid, rot_x, rot_y, rot_z, clipped, zero_norm,
    input  ready
  );
  modport sink (
    input  valid, rot_x, rot_y, rot_z, clipped, zero_norm,
    output ready
  );
endinterface

`default_nettype wire

### rtl/quaternion_vector_rotate.sv
// ----------------------------------------------------------------------------
// quaternion_vector_rotate
// Rotates a vector by q * (0,v) * conj(q) / |q|^2, rounded and saturated.
//
//   channel   role     payload
//   item_i    sink     quat_w/x/y/z (Q1.14), vec_x/y/z
//   res_o     source   rot_x/y/z, clipped, zero_norm
//
// One item per cycle while the output is not stalled. The restoring
// divider gives one quotient bit per stage, behind five front-end stages
// and the output register.
// Reset clears the valid bits only.
// Each stage holds while its successor stalls and takes an item when empty,
// so bubbles close up; a stalled output blocks the input once all stages hold.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module quaternion_vector_rotate #(
  parameter int unsigned VEC_WIDTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  qvr_in_if.sink    item_i,
  qvr_out_if.source res_o
);

  localparam int unsigned RW = qvr_pkg::DEN_W + VEC_WIDTH + 1;
  localparam int unsigned QB = VEC_WIDTH + 1;

  logic                      vld_c   [QB+1];
  logic                      rdy_c   [QB+1];
  logic [2:0][RW-1:0]        rem_c   [QB+1];
  logic [2:0][QB-1:0]        quo_c   [QB+1];
  qvr_pkg::qvr_den_t         den_c   [QB+1];
  qvr_pkg::qvr_flags_t       flg_c   [QB+1];

  qvr_hamilton #(
    .VEC_WIDTH (VEC_WIDTH)
  ) u_hamilton (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_i),
    .vld_o   (vld_c[0]),
    .rdy_i   (rdy_c[0]),
    .dvd_o   (rem_c[0]),
    .den_o   (den_c[0]),
    .flags_o (flg_c[0])
  );

  assign quo_c[0] = '0;

  for (genvar j = 0; j < QB; j++) begin : g_div
    qvr_div_step #(
      .VEC_WIDTH (VEC_WIDTH),
      .SHIFT     (QB - 1 - j)
    ) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .vld_i   (vld_c[j]),
      .rdy_o   (rdy_c[j]),
      .rem_i   (rem_c[j]),
      .quo_i   (quo_c[j]),
      .den_i   (den_c[j]),
      .flags_i (flg_c[j]),
      .vld_o   (vld_c[j+1]),
      .rdy_i   (rdy_c[j+1]),
      .rem_o   (rem_c[j+1]),
      .quo_o   (quo_c[j+1]),
      .den_o   (den_c[j+1]),
      .flags_o (flg_c[j+1])
    );
  end

  qvr_round_sat #(
    .VEC_WIDTH (VEC_WIDTH)
  ) u_round_sat (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vld_i   (vld_c[QB]),
    .rdy_o   (rdy_c[QB]),
    .quo_i   (quo_c[QB]),
    .flags_i (flg_c[QB]),
    .res_o   (res_o)
  );

endmodule

`default_nettype wire

### rtl/qvr_hamilton.sv
// ----------------------------------------------------------------------------
// qvr_hamilton
// Five-stage front end: both Hamilton products, squared norm, and the
// magnitude and sign of each numerator for the divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qvr_hamilton #(
  parameter int unsigned VEC_WIDTH = 16
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  qvr_in_if.sink                                       item_i,
  output logic                                         vld_o,
  input  logic                                         rdy_i,
  output logic [2:0][qvr_pkg::DEN_W+VEC_WIDTH:0]       dvd_o,
  output qvr_pkg::qvr_den_t                            den_o,
  output qvr_pkg::qvr_flags_t                          flags_o
);

  localparam int unsigned QW  = qvr_pkg::QUAT_W;
  localparam int unsigned VW  = VEC_WIDTH;
  localparam int unsigned PW1 = QW + VW;
  localparam int unsigned TW  = PW1 + 2;
  localparam int unsigned PW2 = TW + QW;
  localparam int unsigned NW  = PW2 + 2;
  localparam int unsigned RW  = qvr_pkg::DEN_W + VW + 1;
  localparam int unsigned NST = 5;

  logic [NST-1:0] vld_q;
  logic [NST-1:0] vld_d;
  logic [NST-1:0] vld_in;
  logic [NST:0]   stg_rdy;

  logic signed [QW-1:0] qv [4];
  logic signed [VW-1:0] vv [3];

  logic signed [PW1-1:0]    a_p_q  [4][3];
  logic [2*QW-1:0]          a_sq_q [4];
  logic signed [QW-1:0]     a_q_q  [4];

  logic signed [TW-1:0]     b_t_d  [4];
  logic signed [TW-1:0]     b_t_q  [4];
  qvr_pkg::qvr_den_t        b_den_d;
  qvr_pkg::qvr_den_t        b_den_q;
  logic signed [QW-1:0]     b_q_q  [4];

  logic signed [PW2-1:0]    c_m_q  [4][3];
  qvr_pkg::qvr_den_t        c_den_q;

  logic signed [NW-1:0]     d_n_d  [3];
  logic signed [NW-1:0]     d_n_q  [3];
  qvr_pkg::qvr_den_t        d_den_q;

  logic [NW-1:0]            n_abs  [3];
  logic [2:0][RW-1:0]       e_dvd_d;
  logic [2:0][RW-1:0]       e_dvd_q;
  qvr_pkg::qvr_den_t        e_den_q;
  qvr_pkg::qvr_flags_t      e_flg_d;
  qvr_pkg::qvr_flags_t      e_flg_q;

  assign qv[0] = item_i.quat_w;
  assign qv[1] = item_i.quat_x;
  assign qv[2] = item_i.quat_y;
  assign qv[3] = item_i.quat_z;
  assign vv[0] = item_i.vec_x;
  assign vv[1] = item_i.vec_y;
  assign vv[2] = item_i.vec_z;

  // A stage takes a new item when empty or when its successor takes its own
  always_comb begin
    stg_rdy[NST] = rdy_i;
    for (int k = NST - 1; k >= 0; k--) begin
      stg_rdy[k] = !vld_q[k] || stg_rdy[k+1];
    end
  end

  assign vld_in = {vld_q[NST-2:0], item_i.valid};

  always_comb begin
    for (int k = 0; k < NST; k++) begin
      vld_d[k] = stg_rdy[k] ? vld_in[k] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign item_i.ready = stg_rdy[0];

  // Stage A: q * v partial products, squares
  always_ff @(posedge clk_i) begin
    if (stg_rdy[0] && vld_in[0]) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 3; j++) begin
          a_p_q[i][j] <= PW1'(qv[i]) * PW1'(vv[j]);
        end
        a_sq_q[i] <= unsigned'((2*QW)'(qv[i]) * (2*QW)'(qv[i]));
        a_q_q[i]  <= qv[i];
      end
    end
  end

  // Stage B: t = q * (0, v), squared norm
  always_comb begin
    b_t_d[0] = -(TW'(a_p_q[1][0]) + TW'(a_p_q[2][1]) + TW'(a_p_q[3][2]));
    b_t_d[1] = TW'(a_p_q[0][0]) + TW'(a_p_q[2][2]) - TW'(a_p_q[3][1]);
    b_t_d[2] = TW'(a_p_q[0][1]) + TW'(a_p_q[3][0]) - TW'(a_p_q[1][2]);
    b_t_d[3] = TW'(a_p_q[0][2]) + TW'(a_p_q[1][1]) - TW'(a_p_q[2][0]);
    b_den_d  = qvr_pkg::DEN_W'(a_sq_q[0]) + qvr_pkg::DEN_W'(a_sq_q[1])
             + qvr_pkg::DEN_W'(a_sq_q[2]) + qvr_pkg::DEN_W'(a_sq_q[3]);
  end

  always_ff @(posedge clk_i) begin
    if (stg_rdy[1] && vld_in[1]) begin
      b_t_q   <= b_t_d;
      b_den_q <= b_den_d;
      b_q_q   <= a_q_q;
    end
  end

  // Stage C: t component i times every quaternion component but its own
  always_ff @(posedge clk_i) begin
    if (stg_rdy[2] && vld_in[2]) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 3; j++) begin
          c_m_q[i][j] <= PW2'(b_t_q[i]) * PW2'(b_q_q[(j >= i) ? j + 1 : j]);
        end
      end
      c_den_q <= b_den_q;
    end
  end

  // Stage D: n = t * conj(q)
  always_comb begin
    d_n_d[0] = -NW'(c_m_q[0][0]) + NW'(c_m_q[1][0]) - NW'(c_m_q[2][2]) + NW'(c_m_q[3][2]);
    d_n_d[1] = -NW'(c_m_q[0][1]) + NW'(c_m_q[2][0]) - NW'(c_m_q[3][1]) + NW'(c_m_q[1][2]);
    d_n_d[2] = -NW'(c_m_q[0][2]) + NW'(c_m_q[3][0]) - NW'(c_m_q[1][1]) + NW'(c_m_q[2][1]);
  end

  always_ff @(posedge clk_i) begin
    if (stg_rdy[3] && vld_in[3]) begin
      d_n_q   <= d_n_d;
      d_den_q <= c_den_q;
    end
  end

  // Stage E: sign, magnitude, doubled dividend for the rounding bit
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      n_abs[l]   = d_n_q[l][NW-1] ? unsigned'(-d_n_q[l]) : unsigned'(d_n_q[l]);
      e_dvd_d[l] = {n_abs[l][RW-2:0], 1'b0};
    end
    e_flg_d.neg_x = d_n_q[0][NW-1];
    e_flg_d.neg_y = d_n_q[1][NW-1];
    e_flg_d.neg_z = d_n_q[2][NW-1];
    e_flg_d.zero  = (d_den_q == '0);
  end

  always_ff @(posedge clk_i) begin
    if (stg_rdy[4] && vld_in[4]) begin
      e_dvd_q <= e_dvd_d;
      e_den_q <= d_den_q;
      e_flg_q <= e_flg_d;
    end
  end

  assign vld_o   = vld_q[NST-1];
  assign dvd_o   = e_dvd_q;
  assign den_o   = e_den_q;
  assign flags_o = e_flg_q;

endmodule

`default_nettype wire

### rtl/qvr_div_step.sv
// ----------------------------------------------------------------------------
// qvr_div_step
// One restoring division stage: one quotient bit for each of three lanes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qvr_div_step #(
  parameter int unsigned VEC_WIDTH = 16,
  parameter int unsigned SHIFT     = 0
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   vld_i,
  output logic                                   rdy_o,
  input  logic [2:0][qvr_pkg::DEN_W+VEC_WIDTH:0] rem_i,
  input  logic [2:0][VEC_WIDTH:0]                quo_i,
  input  qvr_pkg::qvr_den_t                      den_i,
  input  qvr_pkg::qvr_flags_t                    flags_i,
  output logic                                   vld_o,
  input  logic                                   rdy_i,
  output logic [2:0][qvr_pkg::DEN_W+VEC_WIDTH:0] rem_o,
  output logic [2:0][VEC_WIDTH:0]                quo_o,
  output qvr_pkg::qvr_den_t                      den_o,
  output qvr_pkg::qvr_flags_t                    flags_o
);

  localparam int unsigned RW = qvr_pkg::DEN_W + VEC_WIDTH + 1;
  localparam int unsigned QB = VEC_WIDTH + 1;

  logic                vld_q;
  logic                vld_d;
  logic [RW:0]         den_sh;
  logic [RW:0]         diff   [3];
  logic [2:0][RW-1:0]  rem_d;
  logic [2:0][RW-1:0]  rem_q;
  logic [2:0][QB-1:0]  quo_d;
  logic [2:0][QB-1:0]  quo_q;
  qvr_pkg::qvr_den_t   den_q;
  qvr_pkg::qvr_flags_t flg_q;

  assign rdy_o  = !vld_q || rdy_i;
  assign vld_d  = rdy_o ? vld_i : vld_q;
  assign den_sh = (RW + 1)'(den_i) << SHIFT;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      diff[l]  = {1'b0, rem_i[l]} - den_sh;
      rem_d[l] = diff[l][RW] ? rem_i[l] : diff[l][RW-1:0];
      quo_d[l] = {quo_i[l][QB-2:0], !diff[l][RW]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_o && vld_i) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
      den_q <= den_i;
      flg_q <= flags_i;
    end
  end

  assign vld_o   = vld_q;
  assign rem_o   = rem_q;
  assign quo_o   = quo_q;
  assign den_o   = den_q;
  assign flags_o = flg_q;

endmodule

`default_nettype wire

### rtl/qvr_round_sat.sv
// ----------------------------------------------------------------------------
// qvr_round_sat
// Output stage: round half away from zero, apply sign, saturate, register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qvr_round_sat #(
  parameter int unsigned VEC_WIDTH = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    vld_i,
  output logic                    rdy_o,
  input  logic [2:0][VEC_WIDTH:0] quo_i,
  input  qvr_pkg::qvr_flags_t     flags_i,
  qvr_out_if.source               res_o
);

  localparam int unsigned VW = VEC_WIDTH;
  localparam int unsigned QB = VW + 1;
  localparam logic [QB-1:0] MAX_POS = {2'b00, {(VW - 1){1'b1}}};
  localparam logic [QB-1:0] MAX_NEG = {2'b01, {(VW - 1){1'b0}}};
  localparam logic [VW-1:0] SAT_POS = {1'b0, {(VW - 1){1'b1}}};
  localparam logic [VW-1:0] SAT_NEG = {1'b1, {(VW - 1){1'b0}}};

  logic                vld_q;
  logic                vld_d;
  logic [QB:0]         inc    [3];
  logic [QB-1:0]       rnd    [3];
  logic [QB-1:0]       neg_v  [3];
  logic [2:0]          sgn;
  logic [2:0]          sat;
  logic [2:0][VW-1:0]  rot_d;
  logic [2:0][VW-1:0]  rot_q;
  logic                clip_d;
  logic                clip_q;
  logic                zero_q;

  assign sgn = {flags_i.neg_z, flags_i.neg_y, flags_i.neg_x};

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      inc[l]   = (QB + 1)'(quo_i[l]) + (QB + 1)'(1);
      rnd[l]   = inc[l][QB:1];
      neg_v[l] = QB'(0) - rnd[l];
      if (sgn[l]) begin
        sat[l]   = rnd[l] > MAX_NEG;
        rot_d[l] = sat[l] ? SAT_NEG : neg_v[l][VW-1:0];
      end else begin
        sat[l]   = rnd[l] > MAX_POS;
        rot_d[l] = sat[l] ? SAT_POS : rnd[l][VW-1:0];
      end
      if (flags_i.zero) begin
        rot_d[l] = '0;
      end
    end
    clip_d = |sat && !flags_i.zero;
  end

  assign rdy_o = !vld_q || res_o.ready;
  assign vld_d = rdy_o ? vld_i : vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_o && vld_i) begin
      rot_q  <= rot_d;
      clip_q <= clip_d;
      zero_q <= flags_i.zero;
    end
  end

  assign res_o.valid     = vld_q;
  assign res_o.rot_x     = rot_q[0];
  assign res_o.rot_y     = rot_q[1];
  assign res_o.rot_z     = rot_q[2];
  assign res_o.clipped   = clip_q;
  assign res_o.zero_norm = zero_q;

endmodule

`default_nettype wire

### rtl/qvr_checker.sv
// ----------------------------------------------------------------------------
// qvr_checker
// Port-level checks on the rotator's result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module qvr_checker #(
  parameter int unsigned VEC_WIDTH = 16
) (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        vld_i,
  input wire logic                        rdy_i,
  input wire logic signed [VEC_WIDTH-1:0] rot_x_i,
  input wire logic signed [VEC_WIDTH-1:0] rot_y_i,
  input wire logic signed [VEC_WIDTH-1:0] rot_z_i,
  input wire logic                        clipped_i,
  input wire logic                        zero_norm_i
);

  localparam logic [VEC_WIDTH-1:0] SAT_POS = {1'b0, {(VEC_WIDTH - 1){1'b1}}};
  localparam logic [VEC_WIDTH-1:0] SAT_NEG = {1'b1, {(VEC_WIDTH - 1){1'b0}}};

  logic x_ext;
  logic y_ext;
  logic z_ext;
  logic zero_ok;
  logic clip_ok;

  assign x_ext = (rot_x_i == SAT_POS) || (rot_x_i == SAT_NEG);
  assign y_ext = (rot_y_i == SAT_POS) || (rot_y_i == SAT_NEG);
  assign z_ext = (rot_z_i == SAT_POS) || (rot_z_i == SAT_NEG);

  assign zero_ok = (rot_x_i == '0) && (rot_y_i == '0) && (rot_z_i == '0) && !clipped_i;
  assign clip_ok = (x_ext || y_ext || z_ext) && !zero_norm_i;

  `QVR_ASSERT_ALWAYS(a_idle_in_reset, clk_i, !rst_ni |-> !vld_i, "result valid during reset")
  `QVR_ASSERT(a_hold_item, clk_i, rst_ni, vld_i && !rdy_i |=> vld_i, "stalled item dropped")
  `QVR_ASSERT(a_zero_norm, clk_i, rst_ni, vld_i && zero_norm_i |-> zero_ok, "zero norm not cleared")
  `QVR_ASSERT(a_clip_limit, clk_i, rst_ni, vld_i && clipped_i |-> clip_ok, "clip without limit")

endmodule

bind quaternion_vector_rotate qvr_checker #(
  .VEC_WIDTH (VEC_WIDTH)
) u_qvr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .vld_i       (res_o.valid),
  .rdy_i       (res_o.ready),
  .rot_x_i     (res_o.rot_x),
  .rot_y_i     (res_o.rot_y),
  .rot_z_i     (res_o.rot_z),
  .clipped_i   (res_o.clipped),
  .zero_norm_i (res_o.zero_norm)
);

`default_nettype wire
